/* src/spfq_pkg.sv */
// Shared types and constants of the strict priority FIFO queue.
// Used by every module of the block but spfq_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package spfq_pkg;

  // Queue geometry
  localparam int DEPTH      = 16;
  localparam int LEVELS     = 3;
  localparam int DATA_WIDTH = 16;

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ADDR_W = $clog2(LEVELS * DEPTH);

  // Port field widths
  localparam int OP_W     = 1;
  localparam int LEVEL_W  = 2;
  localparam int VALUE_W  = 16;
  localparam int STATUS_W = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ENQ = 1'b0;
  localparam logic [OP_W-1:0] OP_DEQ = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the incoming word
    logic exec;    // check, update pointers, access the memory
    logic finish;  // deliver the word read from memory
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic deq_hit; // dequeue found a non-empty level, read in flight
  } stat_t;

endpackage

`default_nettype wire

/* src/spfq_ram.sv */
// Generic single-port RAM with registered read.
// Standalone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module spfq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/spfq_ctrl.sv */
// Controller state machine of the strict priority FIFO queue.
// Depends on spfq_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module spfq_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire spfq_pkg::stat_t stat_i,
  output spfq_pkg::cmd_t      cmd_o,
  output logic                busy_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = stat_i.deq_hit ? ST_RESP : ST_IDLE;
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands to the datapath
  always_comb begin
    cmd_o.load   = (state_q == ST_IDLE) && start_i;
    cmd_o.exec   = (state_q == ST_EXEC);
    cmd_o.finish = (state_q == ST_RESP);
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

/* src/spfq_dp.sv */
// Datapath of the strict priority FIFO queue: pointers, fill counts,
// entry memory and result registers. Depends on spfq_pkg and spfq_ram.
`timescale 1ns / 1ps
`default_nettype none

module spfq_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire spfq_pkg::cmd_t                      cmd_i,
  input  wire logic [spfq_pkg::OP_W-1:0]           op_i,
  input  wire logic [spfq_pkg::LEVEL_W-1:0]        level_i,
  input  wire logic [spfq_pkg::VALUE_W-1:0]        value_i,
  output spfq_pkg::stat_t                          stat_o,
  output logic                                     done_o,
  output logic      [spfq_pkg::STATUS_W-1:0]       status_o,
  output logic      [spfq_pkg::VALUE_W-1:0]        out_value_o,
  output logic      [spfq_pkg::LEVEL_W-1:0]        out_level_o
);

  // Captured word
  logic [spfq_pkg::OP_W-1:0]    op_q;
  logic [spfq_pkg::LEVEL_W-1:0] lvl_q;
  logic [spfq_pkg::VALUE_W-1:0] val_q;

  // Per-level queue state
  logic [spfq_pkg::PTR_W-1:0] head_q [spfq_pkg::LEVELS];
  logic [spfq_pkg::PTR_W-1:0] tail_q [spfq_pkg::LEVELS];
  logic [spfq_pkg::CNT_W-1:0] cnt_q  [spfq_pkg::LEVELS];

  // Result registers
  logic                            done_q;
  logic [spfq_pkg::STATUS_W-1:0]   status_q;
  logic [spfq_pkg::VALUE_W-1:0]    out_value_q;
  logic [spfq_pkg::LEVEL_W-1:0]    out_level_q;
  logic [spfq_pkg::LVL_W-1:0]      sel_q;

  logic                            is_enq;
  logic                            lvl_in_range;
  logic [spfq_pkg::LVL_W-1:0]      enq_lvl;
  logic                            enq_ok;
  logic                            any_full;
  logic [spfq_pkg::LVL_W-1:0]      deq_lvl;
  logic                            deq_found;
  logic                            deq_hit;
  logic [spfq_pkg::LVL_W-1:0]      acc_lvl;
  logic [spfq_pkg::PTR_W-1:0]      acc_ptr;
  logic [spfq_pkg::ADDR_W-1:0]     ram_addr;
  logic [spfq_pkg::DATA_WIDTH-1:0] ram_rdata;
  logic                            ram_we;
  logic                            ram_re;

  function automatic logic [spfq_pkg::PTR_W-1:0] wrap_next(
    input logic [spfq_pkg::PTR_W-1:0] p
  );
    return (p == spfq_pkg::PTR_W'(spfq_pkg::DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Capture the accepted word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      lvl_q <= level_i;
      val_q <= value_i;
    end
  end

  // Enqueue check: level in range and not full
  assign is_enq       = (op_q == spfq_pkg::OP_ENQ);
  assign lvl_in_range = (int'(lvl_q) < spfq_pkg::LEVELS);
  assign enq_lvl      = spfq_pkg::LVL_W'(lvl_q);
  assign any_full     = (cnt_q[enq_lvl] >= spfq_pkg::CNT_W'(spfq_pkg::DEPTH));
  assign enq_ok       = is_enq && lvl_in_range && !any_full;

  // Lowest-numbered non-empty level
  always_comb begin
    deq_lvl   = '0;
    deq_found = 1'b0;
    for (int l = spfq_pkg::LEVELS - 1; l >= 0; l--) begin
      if (cnt_q[l] != '0) begin
        deq_lvl   = spfq_pkg::LVL_W'(l);
        deq_found = 1'b1;
      end
    end
  end

  assign deq_hit = !is_enq && deq_found;
  assign stat_o.deq_hit = deq_hit;

  // Memory address: level base plus slot pointer
  assign acc_lvl  = is_enq ? enq_lvl : deq_lvl;
  assign acc_ptr  = is_enq ? tail_q[acc_lvl] : head_q[acc_lvl];
  assign ram_addr = spfq_pkg::ADDR_W'(acc_lvl) * spfq_pkg::ADDR_W'(spfq_pkg::DEPTH)
                  + spfq_pkg::ADDR_W'(acc_ptr);
  assign ram_we   = cmd_i.exec && enq_ok;
  assign ram_re   = cmd_i.exec && deq_hit;

  spfq_ram #(
    .WIDTH (spfq_pkg::DATA_WIDTH),
    .DEPTH (spfq_pkg::LEVELS * spfq_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (spfq_pkg::DATA_WIDTH'(val_q)),
    .rdata_o (ram_rdata)
  );

  // Pointer and count updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < spfq_pkg::LEVELS; l++) begin
        head_q[l] <= '0;
        tail_q[l] <= '0;
        cnt_q[l]  <= '0;
      end
    end else if (ram_we) begin
      tail_q[enq_lvl] <= wrap_next(tail_q[enq_lvl]);
      cnt_q[enq_lvl]  <= cnt_q[enq_lvl] + 1'b1;
    end else if (ram_re) begin
      head_q[deq_lvl] <= wrap_next(head_q[deq_lvl]);
      cnt_q[deq_lvl]  <= cnt_q[deq_lvl] - 1'b1;
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (cmd_i.exec && !deq_hit) || cmd_i.finish;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      sel_q       <= deq_lvl;
      out_value_q <= '0;
      out_level_q <= '0;
      if (is_enq) begin
        status_q <= enq_ok ? spfq_pkg::ST_OK : spfq_pkg::ST_OVERFLOW;
      end else begin
        status_q <= deq_found ? spfq_pkg::ST_OK : spfq_pkg::ST_UNDERFLOW;
      end
    end else if (cmd_i.finish) begin
      status_q    <= spfq_pkg::ST_OK;
      out_value_q <= spfq_pkg::VALUE_W'(ram_rdata);
      out_level_q <= spfq_pkg::LEVEL_W'(sel_q);
    end
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign out_value_o = out_value_q;
  assign out_level_o = out_level_q;

endmodule

`default_nettype wire

/* src/strict_priority_fifo_queue.sv */
// Strict priority FIFO queue: three-level priority, one FIFO per level.
// An enqueue or an empty-queue dequeue is done in the EXEC state; a dequeue that
// returns a word also passes through RESP, for the registered read port of the
// shared entry memory. A new word is taken only when the controller is idle again.
// Reset clears pointers, fill counts and the controller; the entry memory is not cleared.
// The receiver cannot stall: each result word is shown for one cycle under done_o.
`timescale 1ns / 1ps
`default_nettype none

module strict_priority_fifo_queue (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [spfq_pkg::OP_W-1:0]     op_i,
  input  wire logic [spfq_pkg::LEVEL_W-1:0]  level_i,
  input  wire logic [spfq_pkg::VALUE_W-1:0]  value_i,
  output logic                               done_o,
  output logic      [spfq_pkg::STATUS_W-1:0] status_o,
  output logic      [spfq_pkg::VALUE_W-1:0]  out_value_o,
  output logic      [spfq_pkg::LEVEL_W-1:0]  out_level_o
);

  spfq_pkg::cmd_t  cmd;
  spfq_pkg::stat_t stat;

  // Sequencer
  spfq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // Queue storage and result path
  spfq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .op_i        (op_i),
    .level_i     (level_i),
    .value_i     (value_i),
    .stat_o      (stat),
    .done_o      (done_o),
    .status_o    (status_o),
    .out_value_o (out_value_o),
    .out_level_o (out_level_o)
  );

endmodule

`default_nettype wire

/* src/spfq_chk.sv */
// Port-level checker for the strict priority FIFO queue, bound to the top.
// Depends on spfq_pkg for status codes.
`timescale 1ns / 1ps
`default_nettype none

module spfq_chk (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic [spfq_pkg::OP_W-1:0]     op_i,
  input wire logic [spfq_pkg::LEVEL_W-1:0]  level_i,
  input wire logic [spfq_pkg::VALUE_W-1:0]  value_i,
  input wire logic                          done_o,
  input wire logic [spfq_pkg::STATUS_W-1:0] status_o,
  input wire logic [spfq_pkg::VALUE_W-1:0]  out_value_o,
  input wire logic [spfq_pkg::LEVEL_W-1:0]  out_level_o
);

  // A taken word keeps the block busy in the next cycle
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after a word was taken");

  // No result in the cycle right after a word is taken
  a_no_early_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !done_o)
    else $error("result strobe too early");

  // Results never come in consecutive cycles
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  // Only defined status codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == spfq_pkg::ST_OK || status_o == spfq_pkg::ST_OVERFLOW ||
                status_o == spfq_pkg::ST_UNDERFLOW))
    else $error("undefined status code");

  // Refused words carry zero payload
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != spfq_pkg::ST_OK) |-> (out_value_o == '0 && out_level_o == '0))
    else $error("nonzero payload on an error status");

endmodule

bind strict_priority_fifo_queue spfq_chk u_chk (.*);

`default_nettype wire

/* tb/sv/strict_priority_fifo_queue_checker.sv */
// Checker for the strict priority FIFO queue: watches the command and result
// channels, predicts each result word and compares it. Depends on spfq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module strict_priority_fifo_queue_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire logic [spfq_pkg::OP_W-1:0]     op_i,
  input  wire logic [spfq_pkg::LEVEL_W-1:0]  level_i,
  input  wire logic [spfq_pkg::VALUE_W-1:0]  value_i,
  input  wire logic                          done_o,
  input  wire logic [spfq_pkg::STATUS_W-1:0] status_o,
  input  wire logic [spfq_pkg::VALUE_W-1:0]  out_value_o,
  input  wire logic [spfq_pkg::LEVEL_W-1:0]  out_level_o,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 results_o,
  output int                                 overflows_o,
  output int                                 underflows_o
);

  typedef struct packed {
    logic [spfq_pkg::STATUS_W-1:0] status;
    logic [spfq_pkg::VALUE_W-1:0]  value;
    logic [spfq_pkg::LEVEL_W-1:0]  level;
  } queue_reply_t;

  // Replies owed by the block, oldest first
  queue_reply_t awaited_replies[$];

  // Shadow copy of the per-level ring buffers
  logic [spfq_pkg::DATA_WIDTH-1:0] slot_words [spfq_pkg::LEVELS][spfq_pkg::DEPTH];
  logic [spfq_pkg::PTR_W-1:0]      rd_ptr     [spfq_pkg::LEVELS];
  logic [spfq_pkg::PTR_W-1:0]      wr_ptr     [spfq_pkg::LEVELS];
  logic [spfq_pkg::CNT_W-1:0]      occupancy  [spfq_pkg::LEVELS];

  queue_reply_t got_reply;
  queue_reply_t want_reply;

  function automatic logic [spfq_pkg::PTR_W-1:0] ptr_advance(
    input logic [spfq_pkg::PTR_W-1:0] p
  );
    return (p == spfq_pkg::PTR_W'(spfq_pkg::DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Apply one command to the shadow queues and return the reply it earns
  function automatic queue_reply_t serve_command(
    input logic [spfq_pkg::OP_W-1:0]    op,
    input logic [spfq_pkg::LEVEL_W-1:0] lvl,
    input logic [spfq_pkg::VALUE_W-1:0] val
  );
    queue_reply_t reply;
    bit           found;
    reply        = '0;
    reply.status = spfq_pkg::ST_OK;
    found        = 1'b0;
    if (op == spfq_pkg::OP_ENQ) begin
      // out-of-range level is refused like a full one
      if (int'(lvl) >= spfq_pkg::LEVELS) begin
        reply.status = spfq_pkg::ST_OVERFLOW;
      end else if (occupancy[lvl] >= spfq_pkg::CNT_W'(spfq_pkg::DEPTH)) begin
        reply.status = spfq_pkg::ST_OVERFLOW;
      end else begin
        slot_words[lvl][wr_ptr[lvl]] = val[spfq_pkg::DATA_WIDTH-1:0];
        wr_ptr[lvl]    = ptr_advance(wr_ptr[lvl]);
        occupancy[lvl] = occupancy[lvl] + 1'b1;
      end
    end else begin
      // lowest-numbered non-empty level wins
      for (int l = 0; l < spfq_pkg::LEVELS; l++) begin
        if (!found && occupancy[l] != '0) begin
          found        = 1'b1;
          reply.value  = spfq_pkg::VALUE_W'(slot_words[l][rd_ptr[l]]);
          reply.level  = spfq_pkg::LEVEL_W'(l);
          rd_ptr[l]    = ptr_advance(rd_ptr[l]);
          occupancy[l] = occupancy[l] - 1'b1;
        end
      end
      if (!found) reply.status = spfq_pkg::ST_UNDERFLOW;
    end
    return reply;
  endfunction

  task automatic note_mismatch(input string what, input queue_reply_t want,
                               input queue_reply_t got);
    fail_count_o++;
    if (fail_count_o <= 10)
      $display("[%0t] %s: expected status=%0d value=%h level=%0d, %s=%0d value=%h level=%0d",
               $realtime, what, want.status, want.value, want.level,
               "got status", got.status, got.value, got.level);
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    results_o    = 0;
    overflows_o  = 0;
    underflows_o = 0;
  end

  // Sample both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_replies.delete();
      for (int l = 0; l < spfq_pkg::LEVELS; l++) begin
        rd_ptr[l]    = '0;
        wr_ptr[l]    = '0;
        occupancy[l] = '0;
      end
      pending_o = 0;
    end else begin
      // result word first: it always belongs to an earlier command
      if (done_o) begin
        got_reply.status = status_o;
        got_reply.value  = out_value_o;
        got_reply.level  = out_level_o;
        results_o++;
        if (status_o == spfq_pkg::ST_OVERFLOW)  overflows_o++;
        if (status_o == spfq_pkg::ST_UNDERFLOW) underflows_o++;
        if (awaited_replies.size() == 0) begin
          note_mismatch("unexpected result word", '0, got_reply);
        end else begin
          want_reply = awaited_replies.pop_front();
          if (got_reply.status !== want_reply.status ||
              got_reply.value  !== want_reply.value  ||
              got_reply.level  !== want_reply.level)
            note_mismatch("result word mismatch", want_reply, got_reply);
        end
      end
      if (start && !busy)
        awaited_replies.push_back(serve_command(op_i, level_i, value_i));
      pending_o = awaited_replies.size();
    end
  end

endmodule

`default_nettype wire

/* tb/sv/strict_priority_fifo_queue_tb.sv */
// Testbench top for the strict priority FIFO queue: drives command words and
// gives the verdict. Depends on spfq_pkg, the block and its checker module.
`timescale 1ns / 1ps
`default_nettype none

module strict_priority_fifo_queue_tb;

  localparam int RANDOM_WORDS = 1225;
  localparam int TAIL_WORDS   = 160;     // final stretch sent back to back
  localparam int CYCLE_LIMIT  = 300000;

  logic                          clk_i   = 1'b0;
  logic                          rst_ni  = 1'b0;
  logic                          start   = 1'b0;
  logic [spfq_pkg::OP_W-1:0]     op_i    = '0;
  logic [spfq_pkg::LEVEL_W-1:0]  level_i = '0;
  logic [spfq_pkg::VALUE_W-1:0]  value_i = '0;
  logic                          busy;
  logic                          done_o;
  logic [spfq_pkg::STATUS_W-1:0] status_o;
  logic [spfq_pkg::VALUE_W-1:0]  out_value_o;
  logic [spfq_pkg::LEVEL_W-1:0]  out_level_o;

  int fail_count;
  int pending;
  int results;
  int overflows;
  int underflows;
  int cycles     = 0;
  int words_sent = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  strict_priority_fifo_queue DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .op_i        (op_i),
    .level_i     (level_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .out_value_o (out_value_o),
    .out_level_o (out_level_o)
  );

  strict_priority_fifo_queue_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .op_i         (op_i),
    .level_i      (level_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .out_value_o  (out_value_o),
    .out_level_o  (out_level_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .overflows_o  (overflows),
    .underflows_o (underflows)
  );

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("strict_priority_fifo_queue verification failed");
      $finish;
    end
  end

  // Present one command word and hold it until the block takes it
  task automatic issue_word(input logic [spfq_pkg::OP_W-1:0]    op,
                            input logic [spfq_pkg::LEVEL_W-1:0] lvl,
                            input logic [spfq_pkg::VALUE_W-1:0] val);
    @(negedge clk_i);
    start   <= 1'b1;
    op_i    <= op;
    level_i <= lvl;
    value_i <= val;
    do @(posedge clk_i); while (busy);
    words_sent++;
  endtask

  // Random idle burst on the command side
  task automatic maybe_pause(input bit allowed);
    int gap;
    if (allowed && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk_i);
      start   <= 1'b0;
      value_i <= spfq_pkg::VALUE_W'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Data words with the all-zero and all-one patterns favored
  function automatic logic [spfq_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return spfq_pkg::VALUE_W'($urandom);
    endcase
  endfunction

  initial begin
    int                           enq_pct;
    int                           hot_level;
    logic [spfq_pkg::LEVEL_W-1:0] lvl;
    enq_pct   = 50;
    hot_level = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: dequeue when empty, enqueue to a nonexistent level
    issue_word(spfq_pkg::OP_DEQ, 2'd3, 16'hFFFF);
    maybe_pause(1'b1);
    issue_word(spfq_pkg::OP_ENQ, 2'd3, 16'hFFFF);
    // fill the lowest-priority level to the brim, then one more
    for (int i = 0; i < spfq_pkg::DEPTH; i++) begin
      issue_word(spfq_pkg::OP_ENQ, 2'd2,
                 (i == 0) ? '0 : ((i == spfq_pkg::DEPTH - 1) ? '1 : pick_value()));
      maybe_pause(1'b1);
    end
    issue_word(spfq_pkg::OP_ENQ, 2'd2, 16'h1234);
    // higher levels must drain first
    issue_word(spfq_pkg::OP_ENQ, 2'd1, 16'h5555);
    issue_word(spfq_pkg::OP_ENQ, 2'd0, 16'hAAAA);
    repeat (3) issue_word(spfq_pkg::OP_DEQ, spfq_pkg::LEVEL_W'($urandom),
                          spfq_pkg::VALUE_W'($urandom));

    // Random: phases lean toward filling or draining, one level favored
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 64 == 0) begin
        case ($urandom_range(0, 3))
          0:       enq_pct = 15;
          1:       enq_pct = 50;
          2:       enq_pct = 80;
          default: enq_pct = 100;
        endcase
        hot_level = $urandom_range(0, spfq_pkg::LEVELS - 1);
      end
      if ($urandom_range(1, 100) <= enq_pct) begin
        if ($urandom_range(0, 15) == 0)
          lvl = 2'd3;
        else if ($urandom_range(0, 1) == 1)
          lvl = spfq_pkg::LEVEL_W'(hot_level);
        else
          lvl = spfq_pkg::LEVEL_W'($urandom_range(0, spfq_pkg::LEVELS - 1));
        issue_word(spfq_pkg::OP_ENQ, lvl, pick_value());
      end else begin
        issue_word(spfq_pkg::OP_DEQ, spfq_pkg::LEVEL_W'($urandom),
                   spfq_pkg::VALUE_W'($urandom));
      end
      maybe_pause(n < RANDOM_WORDS - TAIL_WORDS);
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("Sent %0d command words, checked %0d result words", words_sent, results);
    $display("Refusals seen: %0d overflow, %0d underflow", overflows, underflows);
    if (fail_count == 0)
      $display("strict_priority_fifo_queue verification clean");
    else
      $display("strict_priority_fifo_queue verification failed");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
src/spfq_pkg.sv
src/spfq_ram.sv
src/spfq_ctrl.sv
src/spfq_dp.sv
src/strict_priority_fifo_queue.sv
src/spfq_chk.sv
tb/sv/strict_priority_fifo_queue_checker.sv
tb/sv/strict_priority_fifo_queue_tb.sv
